@@ rtl/velocity_gradient_invariants_defines.svh @@
// Assertion macros for the velocity gradient invariants block.
`ifndef VELOCITY_GRADIENT_INVARIANTS_DEFINES_SVH
`define VELOCITY_GRADIENT_INVARIANTS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VGI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgi: same-cycle check failed");
`define VGI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgi: next-cycle check failed");
`else
`define VGI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VGI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/vgi_pkg.sv @@
package vgi_pkg;

  localparam int SW    = 33;      // S and R entries, Q.17
  localparam int PW    = 66;      // product of two entries
  localparam int W2    = 68;      // S^2 and R^2 entries
  localparam int SPLIT = 34;      // low half of a split operand
  localparam int PP3W  = 68;
  localparam int PP4W  = 70;
  localparam int TR2W  = 70;
  localparam int W3    = 104;
  localparam int W4    = 140;
  localparam int RN    = 34;      // integer root width
  localparam int M2    = 2 * RN;
  localparam int M3    = 3 * RN;
  localparam int M4    = 4 * RN;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

  typedef logic signed [SW-1:0]   s_t;
  typedef logic signed [PW-1:0]   p_t;
  typedef logic signed [W2-1:0]   w2_t;
  typedef logic signed [PP3W-1:0] pp3_t;
  typedef logic signed [PP4W-1:0] pp4_t;
  typedef logic signed [TR2W-1:0] tr2_t;
  typedef logic signed [W3-1:0]   w3_t;
  typedef logic signed [W4-1:0]   w4_t;

  typedef struct packed {
    logic signed [31:0] du_dx;
    logic signed [31:0] dv_dx;
    logic signed [31:0] dw_dx;
    logic signed [31:0] du_dy;
    logic signed [31:0] dv_dy;
    logic signed [31:0] dw_dy;
    logic signed [31:0] du_dz;
    logic signed [31:0] dv_dz;
    logic signed [31:0] dw_dz;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] strain_sq_root;
    logic signed [31:0] rot_sq_root;
    logic signed [31:0] strain_cube_root;
    logic signed [31:0] rot_strain_cube_root;
    logic signed [31:0] rot_strain_fourth_root;
  } out_item_t;

  typedef struct packed {
    logic          neg_s2;
    logic          neg_r2;
    logic          neg_s3;
    logic          neg_r3;
    logic          neg_4;
    logic [M2-1:0] m2s;
    logic [M2-1:0] m2r;
    logic [M3-1:0] m3s;
    logic [M3-1:0] m3r;
    logic [M4-1:0] m4;
  } trace_mag_t;

  // halve the Q.17 root, saturate, restore sign
  function automatic logic signed [31:0] fmt_root(input logic neg, input logic [RN-1:0] root);
    logic [RN-2:0] mag;
    logic [31:0]   res;
    mag = root[RN-1:1];
    res = (|mag[RN-2:31]) ? Q_MAX : {1'b0, mag[30:0]};
    return neg ? -res : res;
  endfunction

endpackage

@@ rtl/vgi_ifs.sv @@
interface vgi_in_if;
  import vgi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vgi_out_if;
  import vgi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/velocity_gradient_invariants.sv @@
// Channel   Dir  Payload                               Transfer
// in_chan   in   nine gradient components, Q16.16      valid && ready
// out_chan  out  five invariant roots, Q16.16          valid && ready
//
// One item per cycle while the output buffer has room. From an input transfer
// to the result entering the output buffer: 3 tensor stages, 4 trace stages
// and 102 root stages, the last set by the fourth root (136-bit square root,
// one bit a stage, followed by a 68-bit square root).
// Reset clears valid bits and the output buffer only.
// A stall freezes the whole pipeline once the two-entry output buffer is full;
// input is still taken while one result waits.
`include "velocity_gradient_invariants_defines.svh"
module velocity_gradient_invariants (
  input  logic      clk,
  input  logic      rst_n,
  vgi_in_if.sink    in_chan,
  vgi_out_if.source out_chan
);
  import vgi_pkg::*;

  localparam int DLY      = M4 / 2;       // first square root of the fourth root
  localparam int ROOT_LAT = DLY + RN;
  localparam logic [1:0] FIFO_DEPTH = 2'd2;

  typedef struct packed {
    logic [3:0]         neg;
    logic [3:0][RN-1:0] root;
  } root4_t;

  logic       pipe_en;
  logic       tn_vld;
  logic       tr_vld;
  s_t         s_w [6];
  w2_t        s2_w [6];
  w2_t        r2_w [6];
  trace_mag_t mag_w;

  logic [ROOT_LAT-1:0] vl_r;
  root4_t    dl_r [DLY];
  root4_t    dl_nxt;
  logic      sg4a;
  logic [M4/2-1:0] rt4a;
  logic      sg4;
  logic [RN-1:0] rt4;
  out_item_t res;

  out_item_t mem_r [2];
  logic      wr_ptr_r;
  logic      rd_ptr_r;
  logic [1:0] cnt_r;
  logic      wr_en;
  logic      rd_en;

  // whole pipeline moves unless the output buffer is full
  assign pipe_en       = (cnt_r != FIFO_DEPTH);
  assign in_chan.ready = pipe_en;

  vgi_tensor u_tensor (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (in_chan.valid),
    .in_item (in_chan.data),
    .out_vld (tn_vld),
    .s_o     (s_w),
    .s2_o    (s2_w),
    .r2_o    (r2_w)
  );

  vgi_trace u_trace (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (tn_vld),
    .s_i     (s_w),
    .s2_i    (s2_w),
    .r2_i    (r2_w),
    .out_vld (tr_vld),
    .mag_o   (mag_w)
  );

  // square and cube roots: 34 stages each
  vgi_sqrt #(.N(RN)) u_sqrt_s2 (
    .clk (clk), .en (pipe_en), .sign_i (mag_w.neg_s2), .m_i (mag_w.m2s),
    .sign_o (dl_nxt.neg[0]), .root_o (dl_nxt.root[0])
  );

  vgi_sqrt #(.N(RN)) u_sqrt_r2 (
    .clk (clk), .en (pipe_en), .sign_i (mag_w.neg_r2), .m_i (mag_w.m2r),
    .sign_o (dl_nxt.neg[1]), .root_o (dl_nxt.root[1])
  );

  vgi_cbrt #(.N(RN)) u_cbrt_s3 (
    .clk (clk), .en (pipe_en), .sign_i (mag_w.neg_s3), .m_i (mag_w.m3s),
    .sign_o (dl_nxt.neg[2]), .root_o (dl_nxt.root[2])
  );

  vgi_cbrt #(.N(RN)) u_cbrt_r3 (
    .clk (clk), .en (pipe_en), .sign_i (mag_w.neg_r3), .m_i (mag_w.m3r),
    .sign_o (dl_nxt.neg[3]), .root_o (dl_nxt.root[3])
  );

  // fourth root as floor of sqrt of floor of sqrt
  vgi_sqrt #(.N(M4/2)) u_sqrt_4a (
    .clk (clk), .en (pipe_en), .sign_i (mag_w.neg_4), .m_i (mag_w.m4),
    .sign_o (sg4a), .root_o (rt4a)
  );

  vgi_sqrt #(.N(RN)) u_sqrt_4b (
    .clk (clk), .en (pipe_en), .sign_i (sg4a), .m_i (rt4a),
    .sign_o (sg4), .root_o (rt4)
  );

  // hold the short roots until the fourth root catches up
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dl_r[0] <= dl_nxt;
      for (int i = 1; i < DLY; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else if (pipe_en) begin
      vl_r <= {vl_r[ROOT_LAT-2:0], tr_vld};
    end
  end

  always_comb begin
    res.strain_sq_root         = fmt_root(dl_r[DLY-1].neg[0], dl_r[DLY-1].root[0]);
    res.rot_sq_root            = fmt_root(dl_r[DLY-1].neg[1], dl_r[DLY-1].root[1]);
    res.strain_cube_root       = fmt_root(dl_r[DLY-1].neg[2], dl_r[DLY-1].root[2]);
    res.rot_strain_cube_root   = fmt_root(dl_r[DLY-1].neg[3], dl_r[DLY-1].root[3]);
    res.rot_strain_fourth_root = fmt_root(sg4, rt4);
  end

  // two-entry output buffer
  assign wr_en = vl_r[ROOT_LAT-1] & pipe_en;
  assign rd_en = out_chan.valid & out_chan.ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assign out_chan.valid = (cnt_r != 2'd0);
  assign out_chan.data  = mem_r[rd_ptr_r];

  `VGI_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= FIFO_DEPTH)
  `VGI_ASSERT_NEXT(a_stall_hold, clk, rst_n, !pipe_en, $stable(vl_r))
  `VGI_ASSERT_NEXT(a_cnt_track, clk, rst_n, wr_en && !rd_en, cnt_r == $past(cnt_r) + 2'd1)

endmodule

@@ rtl/vgi_tensor.sv @@
module vgi_tensor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  vgi_pkg::in_item_t  in_item,
  output logic               out_vld,
  output vgi_pkg::s_t        s_o [6],
  output vgi_pkg::w2_t       s2_o [6],
  output vgi_pkg::w2_t       r2_o [6]
);
  import vgi_pkg::*;

  // operand pairs of the fifteen distinct S products
  localparam int PA [15] = '{0, 1, 2, 3, 4, 5, 0, 1, 2, 0, 1, 2, 1, 3, 4};
  localparam int PB [15] = '{0, 1, 2, 3, 4, 5, 1, 3, 4, 2, 4, 5, 2, 4, 5};

  logic [2:0] vld_r;
  s_t  s_nxt [6];
  s_t  q_nxt [3];
  s_t  s1_r [6];
  s_t  q1_r [3];
  p_t  ps_nxt [15];
  p_t  ps_r [15];
  p_t  pq_nxt [6];
  p_t  pq_r [6];
  s_t  s2d_r [6];
  s_t  s3d_r [6];
  w2_t s2_r [6];
  w2_t r2_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  // stage 1: doubled half-sums and half-differences
  always_comb begin
    s_nxt[0] = {in_item.du_dx, 1'b0};
    s_nxt[1] = s_t'(in_item.dv_dx) + s_t'(in_item.du_dy);
    s_nxt[2] = s_t'(in_item.dw_dx) + s_t'(in_item.du_dz);
    s_nxt[3] = {in_item.dv_dy, 1'b0};
    s_nxt[4] = s_t'(in_item.dw_dy) + s_t'(in_item.dv_dz);
    s_nxt[5] = {in_item.dw_dz, 1'b0};
    q_nxt[0] = s_t'(in_item.dv_dx) - s_t'(in_item.du_dy);
    q_nxt[1] = s_t'(in_item.dw_dx) - s_t'(in_item.du_dz);
    q_nxt[2] = s_t'(in_item.dw_dy) - s_t'(in_item.dv_dz);
  end

  // stage 2: products
  for (genvar g = 0; g < 15; g++) begin : g_ps
    assign ps_nxt[g] = p_t'(s1_r[PA[g]]) * p_t'(s1_r[PB[g]]);
  end

  assign pq_nxt[0] = p_t'(q1_r[0]) * p_t'(q1_r[0]);
  assign pq_nxt[1] = p_t'(q1_r[1]) * p_t'(q1_r[1]);
  assign pq_nxt[2] = p_t'(q1_r[2]) * p_t'(q1_r[2]);
  assign pq_nxt[3] = p_t'(q1_r[1]) * p_t'(q1_r[2]);
  assign pq_nxt[4] = p_t'(q1_r[0]) * p_t'(q1_r[2]);
  assign pq_nxt[5] = p_t'(q1_r[0]) * p_t'(q1_r[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= s_nxt;
      q1_r   <= q_nxt;
      ps_r   <= ps_nxt;
      pq_r   <= pq_nxt;
      s2d_r  <= s1_r;
      s3d_r  <= s2d_r;
      // stage 3: S^2 and R^2
      s2_r[0] <= w2_t'(ps_r[0]) + w2_t'(ps_r[1]) + w2_t'(ps_r[2]);
      s2_r[1] <= w2_t'(ps_r[6]) + w2_t'(ps_r[7]) + w2_t'(ps_r[8]);
      s2_r[2] <= w2_t'(ps_r[9]) + w2_t'(ps_r[10]) + w2_t'(ps_r[11]);
      s2_r[3] <= w2_t'(ps_r[1]) + w2_t'(ps_r[3]) + w2_t'(ps_r[4]);
      s2_r[4] <= w2_t'(ps_r[12]) + w2_t'(ps_r[13]) + w2_t'(ps_r[14]);
      s2_r[5] <= w2_t'(ps_r[2]) + w2_t'(ps_r[4]) + w2_t'(ps_r[5]);
      r2_r[0] <= -(w2_t'(pq_r[0]) + w2_t'(pq_r[1]));
      r2_r[1] <= -w2_t'(pq_r[3]);
      r2_r[2] <= w2_t'(pq_r[4]);
      r2_r[3] <= -(w2_t'(pq_r[0]) + w2_t'(pq_r[2]));
      r2_r[4] <= -w2_t'(pq_r[5]);
      r2_r[5] <= -(w2_t'(pq_r[1]) + w2_t'(pq_r[2]));
    end
  end

  assign out_vld = vld_r[2];
  assign s_o     = s3d_r;
  assign s2_o    = s2_r;
  assign r2_o    = r2_r;

endmodule

@@ rtl/vgi_trace.sv @@
module vgi_trace (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  vgi_pkg::s_t         s_i [6],
  input  vgi_pkg::w2_t        s2_i [6],
  input  vgi_pkg::w2_t        r2_i [6],
  output logic                out_vld,
  output vgi_pkg::trace_mag_t mag_o
);
  import vgi_pkg::*;

  logic [3:0] vld_r;
  pp3_t c3s_lo_r [6];
  pp3_t c3s_hi_r [6];
  pp3_t c3r_lo_r [6];
  pp3_t c3r_hi_r [6];
  pp4_t ll_r [6];
  pp4_t lh_r [6];
  pp4_t hl_r [6];
  pp4_t hh_r [6];
  w3_t  t3s_r [6];
  w3_t  t3r_r [6];
  w4_t  t4_r [6];
  tr2_t tr2s_r [3];
  tr2_t tr2r_r [3];
  w3_t  tr3s_r;
  w3_t  tr3r_r;
  w4_t  tr4_r;
  trace_mag_t mag_nxt;
  trace_mag_t mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // split products, then recombine per term
  for (genvar i = 0; i < 6; i++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) begin
        c3s_lo_r[i] <= $signed({1'b0, s2_i[i][SPLIT-1:0]}) * s_i[i];
        c3s_hi_r[i] <= $signed(s2_i[i][W2-1:SPLIT]) * s_i[i];
        c3r_lo_r[i] <= $signed({1'b0, r2_i[i][SPLIT-1:0]}) * s_i[i];
        c3r_hi_r[i] <= $signed(r2_i[i][W2-1:SPLIT]) * s_i[i];
        ll_r[i] <= $signed({1'b0, r2_i[i][SPLIT-1:0]}) * $signed({1'b0, s2_i[i][SPLIT-1:0]});
        lh_r[i] <= $signed({1'b0, r2_i[i][SPLIT-1:0]}) * $signed(s2_i[i][W2-1:SPLIT]);
        hl_r[i] <= $signed(r2_i[i][W2-1:SPLIT]) * $signed({1'b0, s2_i[i][SPLIT-1:0]});
        hh_r[i] <= $signed(r2_i[i][W2-1:SPLIT]) * $signed(s2_i[i][W2-1:SPLIT]);
        t3s_r[i] <= (w3_t'(c3s_hi_r[i]) <<< SPLIT) + w3_t'(c3s_lo_r[i]);
        t3r_r[i] <= (w3_t'(c3r_hi_r[i]) <<< SPLIT) + w3_t'(c3r_lo_r[i]);
        t4_r[i]  <= (w4_t'(hh_r[i]) <<< (2 * SPLIT))
                  + ((w4_t'(lh_r[i]) + w4_t'(hl_r[i])) <<< SPLIT)
                  + w4_t'(ll_r[i]);
      end
    end
  end

  // diagonal once, off-diagonal twice
  always_ff @(posedge clk) begin
    if (en) begin
      tr2s_r[0] <= tr2_t'(s2_i[0]) + tr2_t'(s2_i[3]) + tr2_t'(s2_i[5]);
      tr2r_r[0] <= tr2_t'(r2_i[0]) + tr2_t'(r2_i[3]) + tr2_t'(r2_i[5]);
      tr2s_r[1] <= tr2s_r[0];
      tr2r_r[1] <= tr2r_r[0];
      tr2s_r[2] <= tr2s_r[1];
      tr2r_r[2] <= tr2r_r[1];
      tr3s_r <= t3s_r[0] + t3s_r[3] + t3s_r[5] + ((t3s_r[1] + t3s_r[2] + t3s_r[4]) <<< 1);
      tr3r_r <= t3r_r[0] + t3r_r[3] + t3r_r[5] + ((t3r_r[1] + t3r_r[2] + t3r_r[4]) <<< 1);
      tr4_r  <= t4_r[0] + t4_r[3] + t4_r[5] + ((t4_r[1] + t4_r[2] + t4_r[4]) <<< 1);
      mag_r  <= mag_nxt;
    end
  end

  // magnitude and sign
  always_comb begin
    tr2_t a2s;
    tr2_t a2r;
    w3_t  a3s;
    w3_t  a3r;
    w4_t  a4;
    a2s = tr2s_r[2][TR2W-1] ? -tr2s_r[2] : tr2s_r[2];
    a2r = tr2r_r[2][TR2W-1] ? -tr2r_r[2] : tr2r_r[2];
    a3s = tr3s_r[W3-1] ? -tr3s_r : tr3s_r;
    a3r = tr3r_r[W3-1] ? -tr3r_r : tr3r_r;
    a4  = tr4_r[W4-1] ? -tr4_r : tr4_r;
    mag_nxt.neg_s2 = tr2s_r[2][TR2W-1];
    mag_nxt.neg_r2 = tr2r_r[2][TR2W-1];
    mag_nxt.neg_s3 = tr3s_r[W3-1];
    mag_nxt.neg_r3 = tr3r_r[W3-1];
    mag_nxt.neg_4  = tr4_r[W4-1];
    mag_nxt.m2s    = a2s[M2-1:0];
    mag_nxt.m2r    = a2r[M2-1:0];
    mag_nxt.m3s    = a3s[M3-1:0];
    mag_nxt.m3r    = a3r[M3-1:0];
    mag_nxt.m4     = a4[M4-1:0];
  end

  assign out_vld = vld_r[3];
  assign mag_o   = mag_r;

endmodule

@@ rtl/vgi_sqrt.sv @@
module vgi_sqrt #(
  parameter int N = 34
) (
  input  logic             clk,
  input  logic             en,
  input  logic             sign_i,
  input  logic [2*N-1:0]   m_i,
  output logic             sign_o,
  output logic [N-1:0]     root_o
);
  import vgi_pkg::*;

  localparam int RW = N + 3;

  logic [RW-1:0]  rem_r [N];
  logic [N-1:0]   root_r [N];
  logic [2*N-1:0] x_r [N];
  logic           sg_r [N];

  // one result bit per stage, restoring
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0]  rem_in;
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  trial;
    logic [RW-1:0]  rem_nxt;
    logic [N-1:0]   root_in;
    logic [N-1:0]   root_nxt;
    logic [2*N-1:0] x_in;
    logic           sg_in;
    logic           ge;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = m_i;
      assign sg_in   = sign_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign sg_in   = sg_r[k-1];
    end
    assign rem_sh   = {rem_in[RW-3:0], x_in[2*N-1 -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {root_in[N-2:0], ge};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        x_r[k]    <= {x_in[2*N-3:0], 2'b00};
        sg_r[k]   <= sg_in;
      end
    end
  end

  assign sign_o = sg_r[N-1];
  assign root_o = root_r[N-1];

endmodule

@@ rtl/vgi_cbrt.sv @@
module vgi_cbrt #(
  parameter int N = 34
) (
  input  logic             clk,
  input  logic             en,
  input  logic             sign_i,
  input  logic [3*N-1:0]   m_i,
  output logic             sign_o,
  output logic [N-1:0]     root_o
);
  import vgi_pkg::*;

  localparam int RW = 2 * N + 6;
  localparam int YW = 2 * N;

  logic [RW-1:0]  rem_r [N];
  logic [N-1:0]   y_r [N];
  logic [YW-1:0]  y2_r [N];
  logic [3*N-1:0] x_r [N];
  logic           sg_r [N];

  // three input bits per stage; y^2 kept alongside y
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0]  rem_in;
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  b;
    logic [RW-1:0]  rem_nxt;
    logic [N-1:0]   y_in;
    logic [N-1:0]   yd;
    logic [YW-1:0]  y2_in;
    logic [YW-1:0]  y2d;
    logic [YW:0]    ysum;
    logic [3*N-1:0] x_in;
    logic           sg_in;
    logic           ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign y_in   = '0;
      assign y2_in  = '0;
      assign x_in   = m_i;
      assign sg_in  = sign_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign y_in   = y_r[k-1];
      assign y2_in  = y2_r[k-1];
      assign x_in   = x_r[k-1];
      assign sg_in  = sg_r[k-1];
    end
    assign rem_sh  = {rem_in[RW-4:0], x_in[3*N-1 -: 3]};
    assign yd      = {y_in[N-2:0], 1'b0};
    assign y2d     = {y2_in[YW-3:0], 2'b00};
    assign ysum    = (YW+1)'(y2d) + (YW+1)'(yd);
    // 3y(y+1)+1
    assign b       = RW'({ysum, 1'b0}) + RW'(ysum) + RW'(1);
    assign ge      = (rem_sh >= b);
    assign rem_nxt = ge ? (rem_sh - b) : rem_sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        y_r[k]   <= {y_in[N-2:0], ge};
        y2_r[k]  <= ge ? (y2d + YW'({yd, 1'b1})) : y2d;
        x_r[k]   <= {x_in[3*N-4:0], 3'b000};
        sg_r[k]  <= sg_in;
      end
    end
  end

  assign sign_o = sg_r[N-1];
  assign root_o = y_r[N-1];

endmodule

@@ tb/tb_velocity_gradient_invariants.sv @@
`timescale 1ns / 1ps

// Testbench for velocity_gradient_invariants.
// Every input transfer is noted by the scoreboard. The scoreboard works out the
// five roots using exact 192-bit arithmetic. Each output transfer is checked
// against the oldest prediction still waiting.
module tb_velocity_gradient_invariants;
  import vgi_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef wide_t mat_t [3][3];

  localparam int NUM_RANDOM  = 930;
  localparam int QUIET_TAIL  = 120;     // items at the end sent with no idling
  localparam int DRAIN_WAIT  = 160;     // > pipeline latency plus output buffer
  localparam int CYCLE_LIMIT = 400000;

  // Predicts the invariants and keeps them in order until the DUT delivers.
  class invariant_scoreboard;
    out_item_t pending_roots[$];
    int        errors;

    function void report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    static function mat_t mat_mul(mat_t a, mat_t b);
      mat_t r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r[i][j] = 0;
          for (int k = 0; k < 3; k++) r[i][j] += a[i][k] * b[k][j];
        end
      end
      return r;
    endfunction

    static function wide_t trace_of(mat_t a, mat_t b);
      wide_t t;
      t = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) t += a[i][j] * b[j][i];
      return t;
    endfunction

    // k-th root of |t|, truncated, halved (Q.17 -> Q16.16), saturated, sign kept
    static function logic signed [31:0] signed_root(wide_t t, int k);
      logic        neg;
      logic [191:0] mag_t, cand, pw;
      logic [63:0] r, mag;
      neg   = t < 0;
      mag_t = neg ? -t : t;
      r     = 0;
      for (int b = 37; b >= 0; b--) begin
        cand = {128'd0, r | (64'd1 << b)};
        pw   = cand;
        for (int i = 1; i < k; i++) pw = pw * cand;
        if (pw <= mag_t) r = cand[63:0];
      end
      mag = r >> 1;
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return neg ? -mag[31:0] : mag[31:0];
    endfunction

    static function out_item_t predict_invariants(in_item_t x);
      mat_t      grad, strain, rot, strain_sq, rot_sq;
      out_item_t y;
      // grad[i][j]: derivative of velocity component j along axis i
      grad[0][0] = x.du_dx; grad[0][1] = x.dv_dx; grad[0][2] = x.dw_dx;
      grad[1][0] = x.du_dy; grad[1][1] = x.dv_dy; grad[1][2] = x.dw_dy;
      grad[2][0] = x.du_dz; grad[2][1] = x.dv_dz; grad[2][2] = x.dw_dz;
      // doubled S and R, so everything stays integral (Q.17)
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          strain[i][j] = grad[i][j] + grad[j][i];
          rot[i][j]    = grad[i][j] - grad[j][i];
        end
      end
      strain_sq = mat_mul(strain, strain);
      rot_sq    = mat_mul(rot, rot);
      y.strain_sq_root         = signed_root(strain_sq[0][0] + strain_sq[1][1]
                                             + strain_sq[2][2], 2);
      y.rot_sq_root            = signed_root(rot_sq[0][0] + rot_sq[1][1] + rot_sq[2][2], 2);
      y.strain_cube_root       = signed_root(trace_of(strain_sq, strain), 3);
      y.rot_strain_cube_root   = signed_root(trace_of(rot_sq, strain), 3);
      y.rot_strain_fourth_root = signed_root(trace_of(rot_sq, strain_sq), 4);
      return y;
    endfunction

    function void note(in_item_t x);
      pending_roots.push_back(predict_invariants(x));
    endfunction

    function void cmp(string field, logic [31:0] got, logic [31:0] exp);
      if (got !== exp) report($sformatf("%s got %h expected %h", field, got, exp));
    endfunction

    function void check(out_item_t got);
      out_item_t exp;
      if (pending_roots.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp = pending_roots.pop_front();
      cmp("strain_sq_root", got.strain_sq_root, exp.strain_sq_root);
      cmp("rot_sq_root", got.rot_sq_root, exp.rot_sq_root);
      cmp("strain_cube_root", got.strain_cube_root, exp.strain_cube_root);
      cmp("rot_strain_cube_root", got.rot_strain_cube_root, exp.rot_strain_cube_root);
      cmp("rot_strain_fourth_root", got.rot_strain_fourth_root,
          exp.rot_strain_fourth_root);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet;      // no idling on either side in the closing stretch
  int   cycles = 0;

  vgi_in_if  in_chan ();
  vgi_out_if out_chan ();

  velocity_gradient_invariants i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  invariant_scoreboard sb = new();

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Transfer monitor: sampled at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) sb.note(in_chan.data);
    if (rst_n && out_chan.valid && out_chan.ready) sb.check(out_chan.data);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side backpressure: bursts of stall, then bursts of readiness
  initial begin
    out_chan.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Hold valid for one transfer; optional idle burst beforehand
  task automatic send_gradient(in_item_t x);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= x;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send9(int a, int b, int c, int d, int e, int f, int g, int h, int i);
    in_item_t x;
    x.du_dx = a; x.dv_dx = b; x.dw_dx = c;
    x.du_dy = d; x.dv_dy = e; x.dw_dy = f;
    x.du_dz = g; x.dv_dz = h; x.dw_dz = i;
    send_gradient(x);
  endtask

  // Full range, or a random value shifted down so that magnitudes spread out
  function automatic int rand_comp();
    int v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) return v;
    return v >>> $urandom_range(1, 31);
  endfunction

  task automatic send_random();
    int       c[9];
    in_item_t x;
    foreach (c[k]) c[k] = rand_comp();
    case ($urandom_range(0, 5))
      0: begin        // pure strain: symmetric tensor
        c[3] = c[1]; c[6] = c[2]; c[7] = c[5];
      end
      1: begin        // pure rotation: antisymmetric, zero diagonal
        c[0] = 0; c[4] = 0; c[8] = 0;
        c[3] = -c[1]; c[6] = -c[2]; c[7] = -c[5];
      end
      default: ;
    endcase
    x.du_dx = c[0]; x.dv_dx = c[1]; x.dw_dx = c[2];
    x.du_dy = c[3]; x.dv_dy = c[4]; x.dw_dy = c[5];
    x.du_dz = c[6]; x.dv_dz = c[7]; x.dw_dz = c[8];
    send_gradient(x);
  endtask

  initial begin
    int mx, mn, one;
    mx  = 32'h7FFF_FFFF;
    mn  = 32'h8000_0000;
    one = 32'h0001_0000;
    rst_n         = 1'b0;
    quiet         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, extremes, single components, pure strain and rotation
    send9(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send9(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    send9(mn, mn, mn, mn, mn, mn, mn, mn, mn);
    send9(mx, mn, mx, mn, mx, mn, mx, mn, mx);
    send9(mn, mx, mn, mx, mn, mx, mn, mx, mn);
    send9(one, 0, 0, 0, 0, 0, 0, 0, 0);
    send9(-one, 0, 0, 0, 0, 0, 0, 0, 0);
    send9(0, 0, 0, 0, 0, 0, 0, 0, -one);
    send9(0, one, 0, 0, 0, 0, 0, 0, 0);           // shear: strain and rotation mixed
    send9(0, one, 0, -one, 0, 0, 0, 0, 0);        // pure rotation about z
    send9(0, 0, one, 0, 0, 0, -one, 0, 0);
    send9(0, 0, 0, 0, 0, one, 0, -one, 0);
    send9(0, one, 0, one, 0, 0, 0, 0, 0);         // pure shear strain
    send9(one, 0, 0, 0, one, 0, 0, 0, -2 * one);  // trace-free stretch
    send9(-one, 0, 0, 0, -one, 0, 0, 0, 2 * one);
    send9(1, 0, 0, 0, 0, 0, 0, 0, 0);             // smallest nonzero
    send9(-1, 1, -1, 1, -1, 1, -1, 1, -1);
    send9(mx, 0, 0, 0, 0, 0, 0, 0, 0);            // saturating magnitude
    send9(0, mx, 0, mn, 0, 0, 0, 0, 0);
    send9(0, 0, mn, 0, 0, mx, mx, mn, 0);
    send9(one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one);
    send9(-1, -1, -1, -1, -1, -1, -1, -1, -1);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      send_random();
    end
    in_chan.valid <= 1'b0;

    while (sb.pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.pending_roots.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_roots.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
